// ===== rtl/core/tider_pkg.sv =====
// Types and constants shared by the trigger id extension block.
// No dependencies; imported by tider_eval, trigger_id_extend_recover, tider_sb_pkg and tb_top.
package tider_pkg;

  typedef enum logic [1:0] {
    ST_IN_SEQ    = 2'd0,
    ST_RECOVERED = 2'd1,
    ST_BROKEN    = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  localparam logic [15:0] GAP_WINDOW_RESET = 16'd200;

  // Tracking state carried from frame to frame.
  typedef struct packed {
    logic [31:0] expected;
    logic        awaiting_first;
    logic [31:0] frames;
    logic [31:0] bad;
    logic [31:0] overflow;
  } trk_state_t;

endpackage

// ===== rtl/core/tider_eval.sv =====
// Per-frame evaluation: extends the low trigger bits, checks for gaps and
// computes the next tracking state. Pure combinational; uses tider_pkg.
module tider_eval
  import tider_pkg::*;
#(
  parameter int LOW_BITS = 15
) (
  input  logic [LOW_BITS-1:0] trig_low,
  input  logic                buf_full,
  input  logic [15:0]         gap_window,
  input  trk_state_t          cur,
  output trk_state_t          nxt,
  output status_t             status,
  output logic [31:0]         trig_number
);

  localparam logic [31:0] EPOCH_STEP = 32'd1 << LOW_BITS;

  logic [31:0] exp_base;
  logic [31:0] cand_same;
  logic [31:0] cand_next;
  logic [31:0] gap_ext;
  logic [31:0] diff_same;
  logic [31:0] diff_next;
  logic        mismatch;
  logic        ok_same;
  logic        ok_next;
  logic [31:0] exp_hit;

  always_comb begin
    exp_base  = cur.awaiting_first ? {{(32-LOW_BITS){1'b0}}, trig_low} : cur.expected;
    mismatch  = trig_low != exp_base[LOW_BITS-1:0];
    cand_same = {exp_base[31:LOW_BITS], trig_low};
    cand_next = cand_same + EPOCH_STEP;
    gap_ext   = {16'd0, gap_window};
    diff_same = cand_same - exp_base;
    diff_next = cand_next - exp_base;
    ok_same   = (cand_same > exp_base) && (diff_same < gap_ext);
    ok_next   = (cand_next > exp_base) && (diff_next < gap_ext);
    exp_hit   = ok_same ? cand_same : cand_next;

    nxt         = cur;
    nxt.frames  = cur.frames + 32'd1;
    status      = ST_IN_SEQ;
    trig_number = 32'd0;

    if (buf_full) begin
      nxt.overflow = cur.overflow + 32'd1;
      status       = ST_OVERFLOW;
    end else begin
      nxt.awaiting_first = 1'b0;
      if (!mismatch) begin
        trig_number  = exp_base - 32'd1;
        nxt.expected = exp_base + 32'd1;
      end else if (ok_same || ok_next) begin
        status       = ST_RECOVERED;
        trig_number  = exp_hit - 32'd1;
        nxt.expected = exp_hit + 32'd1;
      end else begin
        // broken id: drop, but still step past it
        status       = ST_BROKEN;
        nxt.bad      = cur.bad + 32'd1;
        nxt.expected = exp_base + 32'd1;
      end
    end
  end

endmodule

// ===== rtl/core/trigger_id_extend_recover.sv =====
// Top level of the trigger id extension and gap recovery block.
// Uses tider_pkg and tider_eval.
//
// Takes one frame per clock unless in_stall is high and returns one result
// per frame; each frame goes through the input register, then the result
// register. The tracking state (expected trigger number and the frame,
// broken and overflow counters) is updated as a frame moves into the result
// register, so back-to-back frames see each other's updates. A stalled
// result holds the input side only once both registers are full. The user
// must write gap_window via the cfg port only while no frame is in flight;
// the block does not enforce it. A jump must be strictly below it; reset 200.
module trigger_id_extend_recover
  import tider_pkg::*;
#(
  parameter int LOW_BITS = 15
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic [LOW_BITS-1:0] in_trigger_low,
  input  logic                in_buffer_full,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [31:0]         out_trigger_number,
  output logic [31:0]         out_frames_seen,
  output logic [31:0]         out_bad_count,
  output logic [31:0]         out_overflow_count,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_gap_window
);

  logic                in_vld_r;
  logic                in_vld_nxt;
  logic [LOW_BITS-1:0] in_low_r;
  logic                in_full_r;
  logic                out_vld_r;
  logic                out_vld_nxt;
  logic [1:0]          out_status_r;
  logic [31:0]         out_number_r;
  logic [31:0]         out_frames_r;
  logic [31:0]         out_bad_r;
  logic [31:0]         out_ovf_r;
  logic [15:0]         gap_r;
  trk_state_t          trk_r;
  trk_state_t          trk_nxt;
  status_t             eval_status;
  logic [31:0]         eval_number;
  logic                in_accept;
  logic                res_load;

  tider_eval #(
    .LOW_BITS (LOW_BITS)
  ) u_eval (
    .trig_low    (in_low_r),
    .buf_full    (in_full_r),
    .gap_window  (gap_r),
    .cur         (trk_r),
    .nxt         (trk_nxt),
    .status      (eval_status),
    .trig_number (eval_number)
  );

  assign res_load  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !res_load;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_accept) begin
      in_vld_nxt = 1'b1;
    end else if (res_load) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r && out_stall;
    if (res_load) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r             <= 1'b0;
      out_vld_r            <= 1'b0;
      gap_r                <= GAP_WINDOW_RESET;
      trk_r.expected       <= 32'd0;
      trk_r.awaiting_first <= 1'b1;
      trk_r.frames         <= 32'd0;
      trk_r.bad            <= 32'd0;
      trk_r.overflow       <= 32'd0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        gap_r <= cfg_gap_window;
      end
      if (res_load) begin
        trk_r <= trk_nxt;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_low_r  <= in_trigger_low;
      in_full_r <= in_buffer_full;
    end
    if (res_load) begin
      out_status_r <= eval_status;
      out_number_r <= eval_number;
      out_frames_r <= trk_nxt.frames;
      out_bad_r    <= trk_nxt.bad;
      out_ovf_r    <= trk_nxt.overflow;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_status         = out_status_r;
  assign out_trigger_number = out_number_r;
  assign out_frames_seen    = out_frames_r;
  assign out_bad_count      = out_bad_r;
  assign out_overflow_count = out_ovf_r;

endmodule

// ===== dv/tider_sb_pkg.sv =====
// Scoreboard for the trigger id extension block: tracks the expected trigger
// number and the frame counters, and queues one expected result per frame.
// Depends on tider_pkg for the status codes and the gap window reset value.
package tider_sb_pkg;
  import tider_pkg::*;

  localparam int          LOW_BITS   = 15;
  localparam logic [31:0] LOW_MASK   = 32'((64'd1 << LOW_BITS) - 64'd1);
  localparam logic [31:0] EPOCH_STEP = 32'(64'd1 << LOW_BITS);

  typedef struct packed {
    status_t     status;
    logic [31:0] number;
    logic [31:0] frames;
    logic [31:0] bad;
    logic [31:0] ovf;
  } trig_result_t;

  class trig_scoreboard;
    logic [31:0]  expected;
    bit           awaiting_first;
    logic [31:0]  frames;
    logic [31:0]  bad;
    logic [31:0]  ovf;
    logic [15:0]  gap_window;
    trig_result_t results_q[$];
    int unsigned  fail_cnt;

    function new();
      expected       = '0;
      awaiting_first = 1'b1;
      frames         = '0;
      bad            = '0;
      ovf            = '0;
      gap_window     = GAP_WINDOW_RESET;
      fail_cnt       = 0;
    endfunction

    function int pending();
      return results_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_cnt++;
    endtask

    // strictly ahead of the expected number, by less than the window
    function bit ahead(logic [31:0] cand);
      return (cand > expected) && ((cand - expected) < {16'd0, gap_window});
    endfunction

    function void note_frame(logic [LOW_BITS-1:0] trig_low, logic buf_full);
      logic [31:0]  low32;
      logic [31:0]  same;
      logic [31:0]  nxt;
      trig_result_t res;
      low32      = 32'(trig_low);
      res.status = ST_IN_SEQ;
      res.number = '0;
      frames++;
      if (buf_full) begin
        ovf++;
        res.status = ST_OVERFLOW;
      end else begin
        if (awaiting_first) begin
          awaiting_first = 1'b0;
          expected       = low32;
        end
        if (low32 != (expected & LOW_MASK)) begin
          same = (expected & ~LOW_MASK) + low32;
          nxt  = same + EPOCH_STEP;
          if (ahead(same)) begin
            expected   = same;
            res.status = ST_RECOVERED;
          end else if (ahead(nxt)) begin
            expected   = nxt;
            res.status = ST_RECOVERED;
          end else begin
            expected++;
            bad++;
            res.status = ST_BROKEN;
          end
        end
        if (res.status != ST_BROKEN) begin
          res.number = expected - 32'd1;
          expected++;
        end
      end
      res.frames = frames;
      res.bad    = bad;
      res.ovf    = ovf;
      results_q  = {results_q, res};
    endfunction

    task check_result(logic [1:0] st, logic [31:0] num, logic [31:0] fr,
                      logic [31:0] bd, logic [31:0] ov);
      trig_result_t want;
      if (results_q.size() == 0) begin
        report($sformatf("result beat with nothing expected (status %0h)", st));
        return;
      end
      want = results_q.pop_front();
      if (st !== want.status)
        report($sformatf("status got %0h want %0h", st, want.status));
      if (num !== want.number)
        report($sformatf("trigger_number got %0h want %0h", num, want.number));
      if (fr !== want.frames)
        report($sformatf("frames_seen got %0h want %0h", fr, want.frames));
      if (bd !== want.bad)
        report($sformatf("bad_count got %0h want %0h", bd, want.bad));
      if (ov !== want.ovf)
        report($sformatf("overflow_count got %0h want %0h", ov, want.ovf));
    endtask
  endclass

endpackage

// ===== dv/tb_top.sv =====
// Top-level testbench for trigger_id_extend_recover: directed and random frames
// with random gaps and stalls on both sides, checked against tider_sb_pkg.
// Depends on tider_pkg, tider_sb_pkg and the block's RTL.
module tb_top
  import tider_pkg::*;
  import tider_sb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_LEN   = 80;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_LEN  = 65;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [LOW_BITS-1:0] in_trigger_low;
  logic                in_buffer_full;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          out_status;
  logic [31:0]         out_trigger_number;
  logic [31:0]         out_frames_seen;
  logic [31:0]         out_bad_count;
  logic [31:0]         out_overflow_count;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [15:0]         cfg_gap_window;

  trig_scoreboard sb;
  bit send_calm;
  bit recv_calm;
  int hold_seq;
  int idle_cycles;

  trigger_id_extend_recover #(.LOW_BITS(LOW_BITS)) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_trigger_low     (in_trigger_low),
    .in_buffer_full     (in_buffer_full),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_trigger_number (out_trigger_number),
    .out_frames_seen    (out_frames_seen),
    .out_bad_count      (out_bad_count),
    .out_overflow_count (out_overflow_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_gap_window     (cfg_gap_window)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65)
      return 0;
    else if (r < 95)
      return $urandom_range(1, 3);
    else
      return $urandom_range(10, 40);
  endfunction

  // low bits of the expected trigger number plus an offset
  function automatic logic [LOW_BITS-1:0] rel_low(int off);
    return LOW_BITS'(sb.expected + 32'(off));
  endfunction

  // Mostly in-sequence frames, plus gaps around the window edge, stale ids,
  // next-epoch probes, junk and buffer-full drops.
  function automatic void gen_frame(output logic [LOW_BITS-1:0] low, output logic full);
    logic [31:0] base;
    logic [31:0] win;
    int          r;
    base = sb.awaiting_first ? $urandom : sb.expected;
    win  = (sb.gap_window == 16'd0) ? 32'd1 : {16'd0, sb.gap_window};
    r    = $urandom_range(0, 99);
    full = 1'b0;
    if (r < 8) begin
      full = 1'b1;
      low  = LOW_BITS'($urandom);
    end else if (r < 60)
      low = LOW_BITS'(base);
    else if (r < 72)
      low = LOW_BITS'(base + $urandom_range(1, 8));
    else if (r < 78)
      low = LOW_BITS'(base + win - 32'd1 + $urandom_range(0, 2));
    else if (r < 84)
      low = LOW_BITS'(base - $urandom_range(1, 4));
    else if (r < 88)
      low = LOW_BITS'(base + EPOCH_STEP - $urandom_range(1, 16));
    else
      low = LOW_BITS'($urandom);
  endfunction

  // valid stays up for back-to-back beats; the caller lowers it for a gap
  task automatic send_frame(logic [LOW_BITS-1:0] low, logic full);
    in_valid       <= 1'b1;
    in_trigger_low <= low;
    in_buffer_full <= full;
    do @(posedge clk); while (in_stall);
    sb.note_frame(low, full);
  endtask

  task automatic idle_in(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_random(int n);
    logic [LOW_BITS-1:0] low;
    logic                full;
    for (int i = 0; i < n; i++) begin
      gen_frame(low, full);
      send_frame(low, full);
      idle_in(pick_gap(send_calm));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_gap(logic [15:0] value);
    wait_drained();
    cfg_valid      <= 1'b1;
    cfg_gap_window <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.gap_window = value;
    cfg_valid <= 1'b0;
  endtask

  // result side: check accepted beats, then pick the next stall value
  initial begin
    int stall_left;
    int hold_left;
    int hold_seen;
    int r;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_status, out_trigger_number, out_frames_seen,
                        out_bad_count, out_overflow_count);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_LEN - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (recv_calm) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall <= 1'b0;
        end else begin
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
          out_stall <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [LOW_BITS-1:0] dir_low[14];
    logic                dir_full[14];
    sb          = new();
    send_calm   = 1'b0;
    recv_calm   = 1'b0;
    in_valid       <= 1'b0;
    in_trigger_low <= '0;
    in_buffer_full <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_gap_window <= '0;
    rst_n          <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset window of 200: drops before the seed, seed of zero, gap just
    // below and at the window, stale id, junk ids.
    dir_low  = '{15'h1234, 15'h7fff, 15'd0, 15'd1, 15'h7fff, 15'd3, 15'd202,
                 15'd403, 15'd204, 15'd204, 15'd203, 15'h5555, 15'h2aaa, 15'd208};
    dir_full = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    for (int i = 0; i < 14; i++) begin
      send_frame(dir_low[i], dir_full[i]);
      idle_in(pick_gap(1'b0));
    end
    send_random(PHASE_LEN);

    // zero window: any mismatch is broken
    write_gap(16'd0);
    send_frame(rel_low(1), 1'b0);
    send_frame(rel_low(0), 1'b0);
    send_random(PHASE_LEN);

    write_gap(16'd1);
    send_random(PHASE_LEN);

    // widest window: large jumps within and across epochs
    write_gap(16'hffff);
    send_frame(rel_low(32'h7ffe), 1'b0);
    send_frame(rel_low(-3), 1'b0);
    send_frame(rel_low(0), 1'b0);
    send_calm = 1'b1;
    recv_calm = 1'b1;
    send_random(40);
    recv_calm = 1'b0;
    // long result hold while frames keep coming, to back up the input side
    hold_seq++;
    send_random(20);
    send_calm = 1'b0;
    send_random(40);

    write_gap(16'd2);
    send_random(PHASE_LEN);

    write_gap(16'h8000);
    send_random(30);
    wait_drained();
    send_random(35);

    for (int k = 0; k < 3; k++) begin
      write_gap(16'($urandom_range(1, 65535)));
      send_random(PHASE_LEN);
    end

    write_gap(GAP_WINDOW_RESET);
    send_random(PHASE_LEN);

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.fail_cnt == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
